// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL that checks itself (top_k_score_keeper).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, held off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a trigger is followed on the next edge by an outcome.
`define ASSERT_NEXT(label, trig, outcome, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (outcome)) \
    else $error(msg);

`endif

// ----- rtl/tks_pkg.sv -----
// Shared constants and types of the top-K score keeper.
package tks_pkg;

  localparam int unsigned MAX_KEEP_DEF   = 32;
  localparam int unsigned SCORE_BITS_DEF = 32;
  localparam int unsigned ITEM_BITS_DEF  = 24;

  localparam int unsigned RANK_W     = 5;
  localparam int unsigned MIN_SCORE_W = 32;
  localparam int unsigned KEEP_W     = 6;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [MIN_SCORE_W-1:0] MIN_SCORE_RST  = 32'd1;
  localparam logic [KEEP_W-1:0]      KEEP_COUNT_RST = 6'd20;

  // Register index, taken from paddr[2]
  localparam logic REG_MIN_SCORE  = 1'b0;
  localparam logic REG_KEEP_COUNT = 1'b1;

  // Input action codes
  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_DUMP  = 1'b1;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic offer;  // insert the new pair
    logic shift;  // move everything one cell toward the head
  } cell_ctrl_t;

endpackage

// ----- rtl/tks_req_if.sv -----
// Request channel: action, score and item identifier with valid/ready.
interface tks_req_if #(
  parameter int unsigned SCORE_BITS = tks_pkg::SCORE_BITS_DEF,
  parameter int unsigned ITEM_BITS  = tks_pkg::ITEM_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [SCORE_BITS-1:0] score;
  logic [ITEM_BITS-1:0]  item_id;

  modport source (output valid, action, score, item_id, input ready);
  modport sink   (input valid, action, score, item_id, output ready);
endinterface

// ----- rtl/tks_res_if.sv -----
// Result channel: the ranked entries of a dump, one per transfer, with valid/ready.
interface tks_res_if #(
  parameter int unsigned SCORE_BITS = tks_pkg::SCORE_BITS_DEF,
  parameter int unsigned ITEM_BITS  = tks_pkg::ITEM_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ITEM_BITS-1:0]        item_id_res;
  logic [SCORE_BITS-1:0]       score_res;
  logic [tks_pkg::RANK_W-1:0]  rank;
  logic                        empty_res;
  logic                        last;

  modport source (output valid, item_id_res, score_res, rank, empty_res, last, input ready);
  modport sink   (input valid, item_id_res, score_res, rank, empty_res, last, output ready);
endinterface

// ----- rtl/tks_cfg_regs.sv -----
// APB configuration registers: min_score and keep_count.
module tks_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tks_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tks_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tks_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [tks_pkg::MIN_SCORE_W-1:0]    min_score_o,
  output logic [tks_pkg::KEEP_W-1:0]         keep_count_o
);

  logic [tks_pkg::MIN_SCORE_W-1:0] min_score_q;
  logic [tks_pkg::KEEP_W-1:0]      keep_count_q;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q  <= tks_pkg::MIN_SCORE_RST;
      keep_count_q <= tks_pkg::KEEP_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        tks_pkg::REG_MIN_SCORE:  min_score_q  <= pwdata[tks_pkg::MIN_SCORE_W-1:0];
        tks_pkg::REG_KEEP_COUNT: keep_count_q <= pwdata[tks_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tks_pkg::REG_MIN_SCORE:  prdata = min_score_q;
      tks_pkg::REG_KEEP_COUNT: prdata = tks_pkg::CFG_DATA_W'(keep_count_q);
      default:                 prdata = '0;
    endcase
  end

  assign min_score_o  = min_score_q;
  assign keep_count_o = keep_count_q;

endmodule

// ----- rtl/tks_cell.sv -----
// One slot of the sorted chain: holds a pair, inserts or shifts per command.
module tks_cell #(
  parameter int unsigned SCORE_BITS = tks_pkg::SCORE_BITS_DEF,
  parameter int unsigned ITEM_BITS  = tks_pkg::ITEM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tks_pkg::cell_ctrl_t   ctrl_i,
  input  logic [SCORE_BITS-1:0] new_score_i,
  input  logic [ITEM_BITS-1:0]  new_item_i,
  input  logic                  set_valid_i,   // slot kept after this offer
  input  logic                  prev_gt_i,     // upper neighbor outranks the new pair
  input  logic [SCORE_BITS-1:0] prev_score_i,
  input  logic [ITEM_BITS-1:0]  prev_item_i,
  input  logic                  next_valid_i,
  input  logic [SCORE_BITS-1:0] next_score_i,
  input  logic [ITEM_BITS-1:0]  next_item_i,
  output logic                  gt_o,
  output logic                  valid_o,
  output logic [SCORE_BITS-1:0] score_o,
  output logic [ITEM_BITS-1:0]  item_o
);

  logic                  valid_q;
  logic [SCORE_BITS-1:0] score_q, score_d;
  logic [ITEM_BITS-1:0]  item_q, item_d;

  // Strictly greater: equal scores let the newer pair rank above.
  assign gt_o = valid_q && (score_q > new_score_i);

  always_comb begin
    priority if (ctrl_i.shift) begin
      score_d = next_score_i;
      item_d  = next_item_i;
    end else if (ctrl_i.offer && !gt_o && prev_gt_i) begin
      score_d = new_score_i;
      item_d  = new_item_i;
    end else if (ctrl_i.offer && !gt_o) begin
      score_d = prev_score_i;
      item_d  = prev_item_i;
    end else begin
      score_d = score_q;
      item_d  = item_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= next_valid_i;
    end else if (ctrl_i.offer) begin
      valid_q <= set_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    item_q  <= item_d;
  end

  assign valid_o = valid_q;
  assign score_o = score_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/top_k_score_keeper.sv -----
// Top-K score keeper: sorted chain of cells, dump sequencer, output register.
// Offer: one request per cycle while idle; no result.
// Dump: the request enters ST_DUMP, which loads the first result into the output
//   register, then one per cycle while that register is free; input ready stays
//   low until the dump ends, longer while out_o.ready keeps the output register full.
// Reset (async, rst_ni low): store empty, registers to defaults, no result.
`include "assert_macros.svh"
module top_k_score_keeper #(
  parameter int unsigned MAX_KEEP   = tks_pkg::MAX_KEEP_DEF,
  parameter int unsigned SCORE_BITS = tks_pkg::SCORE_BITS_DEF,
  parameter int unsigned ITEM_BITS  = tks_pkg::ITEM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tks_req_if.sink                        in_i,
  tks_res_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tks_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tks_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tks_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  // Count must hold MAX_KEEP itself
  localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);
  // Width for comparing keep_count against the capacity
  localparam int unsigned KW    = (CNT_W > tks_pkg::KEEP_W) ? CNT_W : tks_pkg::KEEP_W;
  // Width for comparing score against min_score
  localparam int unsigned CW    = (SCORE_BITS > tks_pkg::MIN_SCORE_W) ?
                                  SCORE_BITS : tks_pkg::MIN_SCORE_W;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [tks_pkg::MIN_SCORE_W-1:0] min_score;
  logic [tks_pkg::KEEP_W-1:0]      keep_count;

  tks_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .min_score_o  (min_score),
    .keep_count_o (keep_count)
  );

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e                      state_q;
  logic [CNT_W-1:0]            count_q;      // entries kept
  logic [CNT_W-1:0]            remain_q;     // entries left to stream in a dump
  logic [tks_pkg::RANK_W-1:0]  rank_q;       // wraps, so it is the low bits of position

  logic                        out_valid_q;
  logic [ITEM_BITS-1:0]        out_item_q;
  logic [SCORE_BITS-1:0]       out_score_q;
  logic [tks_pkg::RANK_W-1:0]  out_rank_q;
  logic                        out_empty_q;
  logic                        out_last_q;

  logic in_accept, offer_en, dump_go, out_free, emit;
  logic score_pass;

  // Offers never need the output slot, so they flow while a result waits.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign score_pass = CW'(in_i.score) >= CW'(min_score);
  assign offer_en   = in_accept && (in_i.action == tks_pkg::ACT_OFFER) && score_pass;
  assign dump_go    = in_accept && (in_i.action == tks_pkg::ACT_DUMP);
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = (state_q == ST_DUMP) && out_free;

  // Effective keep count: zero counts as one, saturates at the capacity.
  logic [KW-1:0]    keep_ext;
  logic [CNT_W-1:0] keep_eff;
  logic [CNT_W-1:0] n_inc, n_new;

  assign keep_ext = KW'(keep_count);

  always_comb begin
    priority if (keep_ext == '0) begin
      keep_eff = CNT_W'(1);
    end else if (keep_ext > KW'(MAX_KEEP)) begin
      keep_eff = CNT_W'(MAX_KEEP);
    end else begin
      keep_eff = keep_ext[CNT_W-1:0];
    end
    // A full store with the new pair at the bottom stays at capacity.
    n_inc = (count_q == CNT_W'(MAX_KEEP)) ? count_q : count_q + CNT_W'(1);
    n_new = (n_inc > keep_eff) ? keep_eff : n_inc;
  end

  // ---------------------------------------------------------------------------
  // Chain of cells; cell 0 holds the highest entry
  // ---------------------------------------------------------------------------
  tks_pkg::cell_ctrl_t   ctrl;
  logic                  cell_gt    [MAX_KEEP];
  logic [MAX_KEEP-1:0]   cell_valid;
  logic [SCORE_BITS-1:0] cell_score [MAX_KEEP];
  logic [ITEM_BITS-1:0]  cell_item  [MAX_KEEP];

  assign ctrl.offer = offer_en;
  assign ctrl.shift = emit && (remain_q != '0);

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                  prev_gt, next_valid;
    logic [SCORE_BITS-1:0] prev_score, next_score;
    logic [ITEM_BITS-1:0]  prev_item, next_item;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b1;   // nothing above the head: new pair lands here
      assign prev_score = '0;
      assign prev_item  = '0;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_score = cell_score[i-1];
      assign prev_item  = cell_item[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_score = '0;
      assign next_item  = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_score = cell_score[i+1];
      assign next_item  = cell_item[i+1];
    end

    tks_cell #(
      .SCORE_BITS (SCORE_BITS),
      .ITEM_BITS  (ITEM_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_score_i  (in_i.score),
      .new_item_i   (in_i.item_id),
      .set_valid_i  (CNT_W'(i) < n_new),
      .prev_gt_i    (prev_gt),
      .prev_score_i (prev_score),
      .prev_item_i  (prev_item),
      .next_valid_i (next_valid),
      .next_score_i (next_score),
      .next_item_i  (next_item),
      .gt_o         (cell_gt[i]),
      .valid_o      (cell_valid[i]),
      .score_o      (cell_score[i]),
      .item_o       (cell_item[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Dump sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      out_score_q <= '0;
      out_rank_q  <= '0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // A new result loaded this cycle keeps the register full.
      if (out_valid_q && out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (offer_en) begin
            count_q <= n_new;
          end
          if (dump_go) begin
            state_q  <= ST_DUMP;
            remain_q <= count_q;
            rank_q   <= '0;
            count_q  <= '0;   // cells empty themselves as they stream out
          end
        end
        ST_DUMP: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            if (remain_q == '0) begin
              // Empty store: one flagged result
              out_item_q  <= '0;
              out_score_q <= '0;
              out_rank_q  <= '0;
              out_empty_q <= 1'b1;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              out_item_q  <= cell_item[0];
              out_score_q <= cell_score[0];
              out_rank_q  <= rank_q;
              out_empty_q <= 1'b0;
              out_last_q  <= (remain_q == CNT_W'(1));
              rank_q      <= rank_q + tks_pkg::RANK_W'(1);
              remain_q    <= remain_q - CNT_W'(1);
              if (remain_q == CNT_W'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.item_id_res = out_item_q;
  assign out_o.score_res   = out_score_q;
  assign out_o.rank        = out_rank_q;
  assign out_o.empty_res   = out_empty_q;
  assign out_o.last        = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // While idle the valid bits form exactly count_q leading slots.
  `ASSERT_CLK(a_valid_matches_count, (state_q != ST_IDLE) || ($countones(cell_valid) == count_q), "valid bits disagree with entry count")
  // A dump request starts streaming with the count already cleared.
  `ASSERT_NEXT(a_dump_starts, dump_go, (state_q == ST_DUMP) && (count_q == '0), "dump did not start")
  // The count never exceeds the built capacity.
  `ASSERT_CLK(a_count_bound, count_q <= CNT_W'(MAX_KEEP), "entry count above capacity")

endmodule

// ----- sim/top_k_score_keeper_tb.sv -----
// Self-checking testbench of the top-K score keeper: ranked dumps against a queue predictor.
module top_k_score_keeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW          = tks_pkg::SCORE_BITS_DEF;
  localparam int unsigned IW          = tks_pkg::ITEM_BITS_DEF;
  // a dump of a full store plus the output register, with margin
  localparam int unsigned DRAIN_WAIT  = tks_pkg::MAX_KEEP_DEF + 8;
  // cycles with no accepted request or result before giving up
  localparam int unsigned QUIET_LIMIT = 3000;
  // long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 40;

  typedef struct packed {
    logic          action;
    logic [SW-1:0] score;
    logic [IW-1:0] item_id;
  } tks_req_t;

  typedef struct packed {
    logic [IW-1:0]              item_id_res;
    logic [SW-1:0]              score_res;
    logic [tks_pkg::RANK_W-1:0] rank;
    logic                       empty_res;
    logic                       last;
  } ranked_t;

  typedef struct packed {
    logic [SW-1:0] score;
    logic [IW-1:0] item_id;
  } entry_t;

  // Tracks the sorted store and the ranked results each dump must produce.
  class rank_board;
    logic [tks_pkg::MIN_SCORE_W-1:0] min_score;
    logic [tks_pkg::KEEP_W-1:0]      keep_raw;
    entry_t                          kept[$];       // highest score first
    ranked_t                         due_ranks[$];  // oldest expected result first
    int unsigned                     failures;

    function new();
      min_score = tks_pkg::MIN_SCORE_RST;
      keep_raw  = tks_pkg::KEEP_COUNT_RST;
      failures  = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == tks_pkg::REG_MIN_SCORE) min_score = value[tks_pkg::MIN_SCORE_W-1:0];
      else keep_raw = value[tks_pkg::KEEP_W-1:0];
    endfunction

    function int unsigned pending();
      return due_ranks.size();
    endfunction

    function void note_request(tks_req_t r);
      int unsigned lim;
      int unsigned pos;
      entry_t      e;
      ranked_t     res;
      if (r.action == tks_pkg::ACT_OFFER) begin
        // zero keeps one, anything past the capacity keeps all slots
        lim = (keep_raw == 0) ? 1 : (keep_raw > tks_pkg::MAX_KEEP_DEF ?
                                     tks_pkg::MAX_KEEP_DEF : keep_raw);
        if (r.score < min_score) return;  // dropped offers leave the store alone
        pos = 0;
        while (pos < kept.size() && kept[pos].score > r.score) pos++;
        e.score   = r.score;
        e.item_id = r.item_id;
        kept.insert(pos, e);
        // evicts from the tail: lowest score, oldest among ties
        while (kept.size() > lim) void'(kept.pop_back());
      end else begin
        if (kept.size() == 0) begin
          res = '0;
          res.empty_res = 1'b1;
          res.last      = 1'b1;
          due_ranks = {due_ranks, res};
        end else begin
          foreach (kept[i]) begin
            res.item_id_res = kept[i].item_id;
            res.score_res   = kept[i].score;
            res.rank        = i[tks_pkg::RANK_W-1:0];
            res.empty_res   = 1'b0;
            res.last        = (i == kept.size() - 1);
            due_ranks = {due_ranks, res};
          end
          kept.delete();
        end
      end
    endfunction

    function void check_result(ranked_t got);
      ranked_t want;
      if (due_ranks.size() == 0) begin
        $error("unexpected result: item %0h score %0h rank %0d",
               got.item_id_res, got.score_res, got.rank);
        failures++;
        return;
      end
      want = due_ranks.pop_front();
      if (got.item_id_res !== want.item_id_res) begin
        $error("item_id_res: expected %0h, got %0h", want.item_id_res, got.item_id_res);
        failures++;
      end
      if (got.score_res !== want.score_res) begin
        $error("score_res: expected %0h, got %0h", want.score_res, got.score_res);
        failures++;
      end
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, got %0d", want.rank, got.rank);
        failures++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tks_pkg::CFG_ADDR_W-1:0] paddr;
  logic [tks_pkg::CFG_DATA_W-1:0] pwdata;
  logic [tks_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  tks_req_if req_if ();
  tks_res_if res_if ();

  top_k_score_keeper dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rank_board   board;
  bit          steady;       // both sides drop their random idling
  bit          hold_req;     // toggled by the stimulus to ask for a hold-off
  bit          hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Monitor: requests feed the predictor, results are checked in order.
  // Sampling at the edge sees pre-edge values, so the order against the DUT is moot.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      board.note_request({req_if.action, req_if.score, req_if.item_id});
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      board.check_result({res_if.item_id_res, res_if.score_res, res_if.rank,
                          res_if.empty_res, res_if.last});
    end
    // watchdog: only accepted requests or results count as progress
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("top_k_score_keeper_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random back-pressure, a steady stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Offers one request and waits for the handshake; may idle afterwards.
  task automatic put_request(input logic act, input logic [SW-1:0] sc,
                             input logic [IW-1:0] id);
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.score   <= sc;
    req_if.item_id <= id;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (!steady && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Called right after the last request of a burst so it is not taken twice.
  task automatic end_burst();
    req_if.valid <= 1'b0;
  endtask

  // Waits for every expected result, then lets a dump in flight finish.
  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Setup then access phase; the register takes the value on the access edge.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Scores mix tiny values (ties), values near the threshold, extremes and full range.
  function automatic logic [SW-1:0] pick_score(input logic [SW-1:0] floor_val);
    logic [SW-1:0] s;
    case ($urandom_range(3))
      0: s = SW'($urandom_range(40));
      1: s = SW'($urandom());
      2: begin
        case ($urandom_range(4))
          0: s = '0;
          1: s = SW'(1);
          2: s = '1;
          3: s = {1'b1, {(SW-1){1'b0}}};
          default: s = floor_val;
        endcase
      end
      default: s = floor_val - SW'(2) + SW'($urandom_range(200));
    endcase
    return s;
  endfunction

  initial begin
    logic [SW-1:0] min_now;
    logic [tks_pkg::KEEP_W-1:0] keep_now;
    int unsigned n;

    board        = new();
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.action  <= tks_pkg::ACT_OFFER;
    req_if.score   <= '0;
    req_if.item_id <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    steady    <= 1'b0;
    hold_req  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset settings (threshold one LSB, keep 20)
    put_request(tks_pkg::ACT_DUMP, '0, '0);                // empty store: one empty result
    put_request(tks_pkg::ACT_OFFER, '0, 24'h000123);       // below threshold, dropped
    put_request(tks_pkg::ACT_OFFER, 1, '0);                // exactly at threshold, kept
    put_request(tks_pkg::ACT_OFFER, '1, '1);               // top score, top id
    put_request(tks_pkg::ACT_OFFER, 32'h100, 24'hAAAAAA);
    put_request(tks_pkg::ACT_OFFER, 32'h100, 24'h555555);  // tie: newer ranks above
    put_request(tks_pkg::ACT_DUMP, '0, '0);
    end_burst();

    // keep two: tie eviction takes the oldest, a lowest offer bounces off a full store
    drain();
    write_reg(tks_pkg::REG_KEEP_COUNT, 2);
    put_request(tks_pkg::ACT_OFFER, 50, 24'd1);
    put_request(tks_pkg::ACT_OFFER, 40, 24'd2);
    put_request(tks_pkg::ACT_OFFER, 40, 24'd3);
    put_request(tks_pkg::ACT_OFFER, 10, 24'd4);
    put_request(tks_pkg::ACT_DUMP, '0, '0);
    end_burst();

    // lower keep below the count: a dropped offer keeps all, a kept one truncates
    drain();
    write_reg(tks_pkg::REG_KEEP_COUNT, 20);
    put_request(tks_pkg::ACT_OFFER, 5, 24'd11);
    put_request(tks_pkg::ACT_OFFER, 6, 24'd12);
    put_request(tks_pkg::ACT_OFFER, 7, 24'd13);
    put_request(tks_pkg::ACT_OFFER, 8, 24'd14);
    end_burst();
    drain();
    write_reg(tks_pkg::REG_KEEP_COUNT, 0);                 // zero acts as one
    put_request(tks_pkg::ACT_OFFER, 0, 24'd15);
    put_request(tks_pkg::ACT_OFFER, 3, 24'd9);
    put_request(tks_pkg::ACT_DUMP, '0, '0);
    end_burst();

    // highest threshold
    drain();
    write_reg(tks_pkg::REG_MIN_SCORE, 32'hFFFF_FFFF);
    put_request(tks_pkg::ACT_OFFER, 32'hFFFF_FFFE, 24'hF0F0F0);
    put_request(tks_pkg::ACT_OFFER, 32'hFFFF_FFFF, 24'h0F0F0F);
    put_request(tks_pkg::ACT_DUMP, '0, '0);
    end_burst();

    // zero threshold, keep beyond capacity
    drain();
    write_reg(tks_pkg::REG_MIN_SCORE, 0);
    write_reg(tks_pkg::REG_KEEP_COUNT, 63);
    put_request(tks_pkg::ACT_OFFER, 0, 24'd7);
    put_request(tks_pkg::ACT_DUMP, '0, '0);
    end_burst();

    // --- random phases, each under its own settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin min_now = 0;                keep_now = 32; end
        1: begin min_now = 1;                keep_now = 1; end
        2: begin min_now = 16;               keep_now = 8; end
        3: begin
          min_now  = SW'($urandom_range(64));
          keep_now = tks_pkg::KEEP_W'($urandom_range(63));
        end
        4: begin min_now = 32'h8000_0000;    keep_now = 63; end
        5: begin min_now = 0;                keep_now = 0; end
        6: begin
          min_now  = SW'($urandom());
          keep_now = tks_pkg::KEEP_W'($urandom_range(32, 1));
        end
        default: begin min_now = 5;          keep_now = 20; end
      endcase
      drain();
      write_reg(tks_pkg::REG_MIN_SCORE, min_now);
      write_reg(tks_pkg::REG_KEEP_COUNT, 32'(keep_now));
      steady <= (p == 3);
      // hold the receiver off so a dump backs up into the request side
      if (p == 2) hold_req <= ~hold_req;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 2) ? (n % 9 == 8) : ($urandom_range(9) == 0)) begin
          put_request(tks_pkg::ACT_DUMP, SW'($urandom()), IW'($urandom()));
        end else begin
          put_request(tks_pkg::ACT_OFFER, pick_score(min_now), IW'($urandom()));
        end
      end
      end_burst();
    end
    steady <= 1'b0;

    drain();
    if (board.failures == 0) begin
      $display("top_k_score_keeper_tb OK");
    end else begin
      $display("top_k_score_keeper_tb NOT OK");
    end
    $finish;
  end

endmodule
